### sv/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg: shared types, constants and tables for the quaternion-to-bins block
// Holds the pipeline word, the CORDIC arctangent table and the bin count.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int BINS       = 18;
  localparam int STEPS      = 31;
  localparam int SQ_STEPS   = 29;          // isqrt of a 57-bit value, one bit a cell
  localparam int AW         = 34;          // angle accumulator width
  localparam int XW         = 46;          // CORDIC x/y width (2^41 plus growth)
  localparam int TW         = 36;          // Q2.28 term width (|t| <= 2^32)
  localparam int SW         = 58;          // square root remainder width
  localparam int BIN_W      = 5;

  localparam logic signed [AW-1:0] HALF_TURN    = AW'(64'sd2147483648);
  localparam logic signed [AW-1:0] QUARTER_TURN = AW'(64'sd1073741824);
  localparam logic signed [XW-1:0] NORM_LIMIT   = XW'(64'sd1099511627776);
  localparam logic signed [TW-1:0] ONE_Q28      = TW'(64'sd268435456);

  localparam int ATW = 31;
  typedef logic [ATW-1:0] atan_t;

  function automatic atan_t arctab(input logic [4:0] i);
    case (i)
      5'd0:  arctab = 31'h20000000;  5'd1:  arctab = 31'h12E4051E;
      5'd2:  arctab = 31'h09FB385B;  5'd3:  arctab = 31'h051111D4;
      5'd4:  arctab = 31'h028B0D43;  5'd5:  arctab = 31'h0145D7E1;
      5'd6:  arctab = 31'h00A2F61E;  5'd7:  arctab = 31'h00517C55;
      5'd8:  arctab = 31'h0028BE53;  5'd9:  arctab = 31'h00145F2F;
      5'd10: arctab = 31'h000A2F98;  5'd11: arctab = 31'h000517CC;
      5'd12: arctab = 31'h00028BE6;  5'd13: arctab = 31'h000145F3;
      5'd14: arctab = 31'h0000A2FA;  5'd15: arctab = 31'h0000517D;
      5'd16: arctab = 31'h000028BE;  5'd17: arctab = 31'h0000145F;
      5'd18: arctab = 31'h00000A30;  5'd19: arctab = 31'h00000518;
      5'd20: arctab = 31'h0000028C;  5'd21: arctab = 31'h00000146;
      5'd22: arctab = 31'h000000A3;  5'd23: arctab = 31'h00000051;
      5'd24: arctab = 31'h00000029;  5'd25: arctab = 31'h00000014;
      5'd26: arctab = 31'h0000000A;  5'd27: arctab = 31'h00000005;
      5'd28: arctab = 31'h00000003;  5'd29: arctab = 31'h00000001;
      5'd30: arctab = 31'h00000001;
      default: arctab = '0;
    endcase
  endfunction

  // one CORDIC lane in flight
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [AW-1:0] acc;
    logic                 done;   // special case settled, acc final
  } lane_t;

  // square root cell state: remainder, partial root, pitch term carried along
  typedef struct packed {
    logic [SW-1:0]        rem;
    logic [29:0]          root;
    logic signed [TW-1:0] s;
  } sq_t;

endpackage

### sv/quaternion_to_euler_bins.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_bins: unit quaternion to coarse roll/pitch/yaw bins
// Pipelined atan2 / asin through chains of square-root and CORDIC cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes w,x,y,z in signed Q1.14 and a
//   64-bit stamp; output channel (out_valid/out_ready) gives three bins in
//   0..BINS and the stamp unchanged. One result item per input item.
//   Throughput: one item per cycle while the output is not stalled. The
//   whole pipe advances as one when the output register is empty or being
//   taken, so the block accepts a new item while older ones are in flight.
//   Pipeline: 1 product stage, 1 term stage, 29 square-root cells, 1
//   normalize stage, 31 CORDIC cells and 1 bin stage: 64 register stages.
//   Normalizing takes a leading-one search over a 41-bit magnitude in one
//   stage; the square root runs one root bit per cell.
//   Reset clears all valid bits; payload registers are left alone.
//   When the receiver stalls with out_valid high, the pipe freezes as a whole
//   and in_ready drops until the output item is taken.
// ----------------------------------------------------------------------------
module quaternion_to_euler_bins
  import q2e_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic [63:0]        in_stamp_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_roll_bin,
  output logic [4:0]         out_pitch_bin,
  output logic [4:0]         out_yaw_bin,
  output logic [63:0]        out_stamp_out
);

  localparam int DEPTH = 2 + SQ_STEPS + 1 + STEPS + 1;

  logic adv;
  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic [63:0] stamp_r [DEPTH];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[DEPTH-1];

  always_comb begin
    vld_nxt = {vld_r[DEPTH-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // carry the stamp alongside
  always_ff @(posedge clk) begin
    if (adv) begin
      stamp_r[0] <= in_stamp_in;
      for (int k = 1; k < DEPTH; k++) stamp_r[k] <= stamp_r[k-1];
    end
  end
  assign out_stamp_out = stamp_r[DEPTH-1];

  // ---- stage 1: products, Q2.28
  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, zz_r, wz_r, xy_r, wy_r, zx_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      wx_r <= in_quat_w * in_quat_x;  yz_r <= in_quat_y * in_quat_z;
      xx_r <= in_quat_x * in_quat_x;  yy_r <= in_quat_y * in_quat_y;
      zz_r <= in_quat_z * in_quat_z;  wz_r <= in_quat_w * in_quat_z;
      xy_r <= in_quat_x * in_quat_y;  wy_r <= in_quat_w * in_quat_y;
      zx_r <= in_quat_z * in_quat_x;
    end
  end

  // ---- stage 2: terms, clamp pitch term, seed square root
  logic signed [TW-1:0] rn, rd, yn, yd, s_raw, s_cl;
  lane_t r0, w0;
  sq_t   sq0_r;
  always_comb begin
    rn    = (TW'(wx_r) + TW'(yz_r)) <<< 1;
    rd    = ONE_Q28 - ((TW'(xx_r) + TW'(yy_r)) <<< 1);
    yn    = (TW'(wz_r) + TW'(xy_r)) <<< 1;
    yd    = ONE_Q28 - ((TW'(yy_r) + TW'(zz_r)) <<< 1);
    s_raw = (TW'(wy_r) - TW'(zx_r)) <<< 1;
    s_cl  = s_raw;
    if (s_raw > ONE_Q28)  s_cl = ONE_Q28;
    if (s_raw < -ONE_Q28) s_cl = -ONE_Q28;
    r0 = '{x: XW'(rd), y: XW'(rn), acc: '0, done: 1'b0};
    w0 = '{x: XW'(yd), y: XW'(yn), acc: '0, done: 1'b0};
  end

  // clamped term is at most 2^28 in magnitude: square it as 29 x 29 bits
  logic [28:0] s_mag;
  logic [57:0] s_sq;
  assign s_mag = 29'((s_cl < 0) ? -s_cl : s_cl);
  assign s_sq  = 58'(s_mag) * 58'(s_mag);

  always_ff @(posedge clk) begin
    if (adv) begin
      sq0_r.rem  <= (SW'(1) << 56) - SW'(s_sq);
      sq0_r.root <= '0;
      sq0_r.s    <= s_cl;
    end
  end
  lane_t r0_r, w0_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      r0_r <= r0;
      w0_r <= w0;
    end
  end

  // ---- square-root chain: bits 28 down to 0
  sq_t   sqc [SQ_STEPS+1];
  lane_t rc  [SQ_STEPS+1];
  lane_t wc  [SQ_STEPS+1];
  assign sqc[0] = sq0_r;
  assign rc[0]  = r0_r;
  assign wc[0]  = w0_r;

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
    q2e_sqrt_cell u_cell (
      .clk   (clk),
      .step  (5'(SQ_STEPS - 1 - g)),
      .en    (adv),
      .d_in  (sqc[g]),
      .r_in  (rc[g]),
      .w_in  (wc[g]),
      .d_out (sqc[g+1]),
      .r_out (rc[g+1]),
      .w_out (wc[g+1])
    );
  end

  // ---- normalize and pre-rotate all three lanes
  function automatic lane_t prep(input logic signed [XW-1:0] x0,
                                 input logic signed [XW-1:0] y0);
    lane_t l;
    logic signed [XW-1:0] x, y, mx, my, m, t;
    int sh;
    l = '{x: x0, y: y0, acc: '0, done: 1'b1};
    mx = (x0 < 0) ? -x0 : x0;
    my = (y0 < 0) ? -y0 : y0;
    m  = (mx > my) ? mx : my;
    sh = 0;
    for (int b = 0; b <= 40; b++) begin
      if (m[b]) sh = 40 - b;
    end
    x = x0 <<< sh;
    y = y0 <<< sh;
    if (y0 == 0) begin
      l.acc = (x0 < 0) ? HALF_TURN : '0;
    end else if (x0 == 0) begin
      l.acc = (y0 > 0) ? QUARTER_TURN : -QUARTER_TURN;
    end else begin
      l.done = 1'b0;
      l.x = x;
      l.y = y;
      if (x < 0) begin
        t = x;
        if (y > 0) begin
          l.x = y;  l.y = -t; l.acc = QUARTER_TURN;
        end else begin
          l.x = -y; l.y = t;  l.acc = -QUARTER_TURN;
        end
      end
    end
    return l;
  endfunction

  // prep() takes (x, y): pitch lane is atan2(s, c), so x = c, y = s
  lane_t ac [STEPS+1][3];
  always_ff @(posedge clk) begin
    if (adv) begin
      ac[0][0] <= prep(rc[SQ_STEPS].x, rc[SQ_STEPS].y);
      ac[0][1] <= prep(XW'(sqc[SQ_STEPS].root), XW'(sqc[SQ_STEPS].s));
      ac[0][2] <= prep(wc[SQ_STEPS].x, wc[SQ_STEPS].y);
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_cor
    q2e_cordic_cell u_cell (
      .clk   (clk),
      .step  (5'(g)),
      .en    (adv),
      .a_in  (ac[g]),
      .a_out (ac[g+1])
    );
  end

  // ---- bins
  function automatic logic [4:0] to_bin(input logic signed [AW-1:0] a,
                                        input logic signed [AW-1:0] half,
                                        input logic               full);
    logic signed [AW-1:0] c, off;
    logic [AW+8:0] p;
    logic [AW+8:0] b;
    c = a;
    if (c > HALF_TURN)  c = HALF_TURN;
    if (c < -HALF_TURN) c = -HALF_TURN;
    off = c + half;
    if (off < 0) off = '0;
    p = (AW+9)'($unsigned(off)) * (AW+9)'(BINS);
    b = full ? (p >> 32) : (p >> 31);
    if (b > (AW+9)'(BINS)) b = (AW+9)'(BINS);
    return b[4:0];
  endfunction

  logic [4:0] roll_r, pitch_r, yaw_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      roll_r  <= to_bin(ac[STEPS][0].acc, HALF_TURN, 1'b1);
      pitch_r <= to_bin(ac[STEPS][1].acc, QUARTER_TURN, 1'b0);
      yaw_r   <= to_bin(ac[STEPS][2].acc, HALF_TURN, 1'b1);
    end
  end
  assign out_roll_bin  = roll_r;
  assign out_pitch_bin = pitch_r;
  assign out_yaw_bin   = yaw_r;

endmodule

### sv/q2e_sqrt_cell.sv
// ----------------------------------------------------------------------------
// q2e_sqrt_cell: one restoring square-root step
// Resolves one root bit and hands remainder and partial root onward.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell
  import q2e_pkg::*;
(
  input  logic        clk,
  input  logic [4:0]  step,    // bit weight index (2*step is the bit position)
  input  logic        en,
  input  sq_t         d_in,
  input  lane_t       r_in,
  input  lane_t       w_in,
  output sq_t         d_out,
  output lane_t       r_out,
  output lane_t       w_out
);

  sq_t d_nxt;
  sq_t d_r;
  lane_t r_r;
  lane_t w_r;
  logic [SW-1:0] trial;

  // remainder / root form: test (4*root+1) << 2k against remainder
  always_comb begin
    trial = ((SW'(d_in.root) << 2) | SW'(1)) << {step, 1'b0};
    d_nxt = d_in;
    d_nxt.root = d_in.root << 1;
    if (d_in.rem >= trial) begin
      d_nxt.rem  = d_in.rem - trial;
      d_nxt.root = (d_in.root << 1) | 30'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
      r_r <= r_in;
      w_r <= w_in;
    end
  end

  assign d_out = d_r;
  assign r_out = r_r;
  assign w_out = w_r;

endmodule

### sv/q2e_cordic_cell.sv
// ----------------------------------------------------------------------------
// q2e_cordic_cell: one vectoring micro-rotation on three lanes
// Rotates roll, pitch and yaw lanes by step i and passes them on.
// ----------------------------------------------------------------------------
module q2e_cordic_cell
  import q2e_pkg::*;
(
  input  logic        clk,
  input  logic [4:0]  step,
  input  logic        en,
  input  lane_t       a_in [3],
  output lane_t       a_out [3]
);

  lane_t nxt [3];
  lane_t a_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nxt[k] = a_in[k];
      if (!a_in[k].done) begin
        // arithmetic shift floors toward minus infinity
        if (a_in[k].y > 0) begin
          nxt[k].x   = a_in[k].x + (a_in[k].y >>> step);
          nxt[k].y   = a_in[k].y - (a_in[k].x >>> step);
          nxt[k].acc = a_in[k].acc + AW'(arctab(step));
        end else if (a_in[k].y < 0) begin
          nxt[k].x   = a_in[k].x - (a_in[k].y >>> step);
          nxt[k].y   = a_in[k].y + (a_in[k].x >>> step);
          nxt[k].acc = a_in[k].acc - AW'(arctab(step));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= nxt;
    end
  end

  assign a_out = a_r;

endmodule

### sv/q2e_checker.sv
// ----------------------------------------------------------------------------
// q2e_checker: port-level checks for quaternion_to_euler_bins
// Watches handshake, reset behaviour and result range on the top level.
// ----------------------------------------------------------------------------
module q2e_checker
  import q2e_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] out_roll_bin,
  input logic [4:0] out_pitch_bin,
  input logic [4:0] out_yaw_bin
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_roll_bin))
    else $error("output item dropped while stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_roll_bin <= 5'(BINS) && out_pitch_bin <= 5'(BINS)
                  && out_yaw_bin <= 5'(BINS))
    else $error("bin out of range");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting output item");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind quaternion_to_euler_bins q2e_checker u_q2e_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_roll_bin  (out_roll_bin),
  .out_pitch_bin (out_pitch_bin),
  .out_yaw_bin   (out_yaw_bin)
);
